### rtl/ccs_pkg.sv
// Shared types, character codes and queue sizing for the C comment stripper.
`default_nettype none

package ccs_pkg;

   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [3:0] {
      M_NORMAL   = 4'd0,
      M_SLASH    = 4'd1,
      M_LINE     = 4'd2,
      M_LINE_ESC = 4'd3,
      M_LINE_CR  = 4'd4,
      M_BLOCK    = 4'd5,
      M_BLOCK_ST = 4'd6,
      M_BLOCK_CR = 4'd7,
      M_STR      = 4'd8,
      M_STR_ESC  = 4'd9,
      M_CHR      = 4'd10,
      M_CHR_ESC  = 4'd11
   } mode_type;

   // One queue entry: the bytes caused by one input byte, one or two of them.
   typedef struct packed {
      logic       two;
      logic [7:0] b0;
      logic [7:0] b1;
   } entry_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QCNT_W-1:0] count;
   } q_status_type;

   typedef struct packed {
      mode_type mode;
   } front_status_type;

endpackage

`default_nettype wire

### rtl/c_comment_stripper.sv
// A byte accepted by the front end is written into the queue and then loaded into the
// output register, from which its first output beat is taken; bytes swallowed by a
// comment or a held mode show no beat at all.
// Throughput: one input byte per cycle while the queue is not full; one output beat
// per cycle while rsp_pop is held, so an input that produces two bytes gives two beats.
// A four-entry queue between front and back end lets either side stall on its own.
// Synchronous active-high reset returns the scan mode to normal and empties the queue.
`default_nettype none

module c_comment_stripper import ccs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_stream_end,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_run_last
);

   entry_type        push_entry, head_entry;
   logic             q_push, q_pop;
   q_status_type     q_stat;
   front_status_type front_stat;

   assign req_full = q_stat.full;

   ccs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_in_byte    (req_in_byte),
      .req_stream_end (req_stream_end),
      .q_full         (q_stat.full),
      .q_push         (q_push),
      .q_entry        (push_entry),
      .front_stat     (front_stat)
   );

   ccs_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .stat       (q_stat)
   );

   ccs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_entry   (head_entry),
      .q_empty      (q_stat.empty),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

`ifndef ASSERT_OFF
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= QCNT_W'(QDEPTH))
      else $error("queue count beyond its depth");

   a_end_resets_mode: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && req_stream_end) |=> (front_stat.mode == M_NORMAL))
      else $error("scan mode not normal after the final byte of a stream");

   a_no_spurious_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_empty && q_stat.empty) |=> rsp_empty)
      else $error("output beat appeared with nothing queued");
`endif

endmodule

`default_nettype wire

### rtl/ccs_front.sv
// Front end: scan mode register and per-byte classification into queue entries.
`default_nettype none

module ccs_front import ccs_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire logic [7:0]       req_in_byte,
   input  wire logic             req_stream_end,
   input  wire logic             q_full,
   output logic                  q_push,
   output entry_type             q_entry,
   output front_status_type      front_stat
);

   typedef struct packed {
      mode_type nxt;
      logic     emit;
      logic     again;
   } step_type;

   // One pass of the mode table; emit means the pass outputs a byte
   // (the held slash when leaving the held-slash mode, the input byte otherwise).
   function automatic step_type mode_step(mode_type m, logic [7:0] c);
      step_type s;
      s.nxt   = m;
      s.emit  = 1'b0;
      s.again = 1'b0;
      unique case (m)
         M_SLASH: begin
            if (c == CH_SLASH) s.nxt = M_LINE;
            else if (c == CH_STAR) s.nxt = M_BLOCK;
            else begin
               s.emit  = 1'b1;
               s.nxt   = M_NORMAL;
               s.again = 1'b1;
            end
         end
         M_LINE: begin
            if (c == CH_BSLASH) s.nxt = M_LINE_ESC;
            else if (c == CH_LF) begin
               s.emit = 1'b1;
               s.nxt  = M_NORMAL;
            end else if (c == CH_CR) begin
               s.emit = 1'b1;
               s.nxt  = M_LINE_CR;
            end
         end
         M_LINE_ESC: s.nxt = M_LINE;
         M_LINE_CR: begin
            s.nxt = M_NORMAL;
            if (c == CH_LF) s.emit = 1'b1;
            else s.again = 1'b1;
         end
         M_BLOCK: begin
            if (c == CH_STAR) s.nxt = M_BLOCK_ST;
            else if (c == CH_LF) s.emit = 1'b1;
            else if (c == CH_CR) begin
               s.emit = 1'b1;
               s.nxt  = M_BLOCK_CR;
            end
         end
         M_BLOCK_ST: begin
            if (c == CH_SLASH) s.nxt = M_NORMAL;
            else begin
               s.nxt   = M_BLOCK;
               s.again = 1'b1;
            end
         end
         M_BLOCK_CR: begin
            s.nxt = M_BLOCK;
            if (c == CH_LF) s.emit = 1'b1;
            else s.again = 1'b1;
         end
         M_STR: begin
            s.emit = 1'b1;
            if (c == CH_BSLASH) s.nxt = M_STR_ESC;
            else if (c == CH_DQUOTE || c == CH_LF) s.nxt = M_NORMAL;
         end
         M_STR_ESC: begin
            s.emit = 1'b1;
            s.nxt  = M_STR;
         end
         M_CHR: begin
            s.emit = 1'b1;
            if (c == CH_BSLASH) s.nxt = M_CHR_ESC;
            else if (c == CH_SQUOTE || c == CH_LF) s.nxt = M_NORMAL;
         end
         M_CHR_ESC: begin
            s.emit = 1'b1;
            s.nxt  = M_CHR;
         end
         default: begin
            if (c == CH_SLASH) s.nxt = M_SLASH;
            else begin
               s.emit = 1'b1;
               if (c == CH_DQUOTE) s.nxt = M_STR;
               else if (c == CH_SQUOTE) s.nxt = M_CHR;
               else s.nxt = M_NORMAL;
            end
         end
      endcase
      return s;
   endfunction

   mode_type   mode_ff, mode_in;
   step_type   pass1, pass2;
   logic       flush;
   logic       accept;
   logic [7:0] first_byte;

   assign accept = req_push && !q_full;

   always_comb begin
      pass1 = mode_step(mode_ff, req_in_byte);
      // A redirected byte is handled once more in the mode it was sent to.
      if (pass1.again) begin
         pass2 = mode_step(pass1.nxt, req_in_byte);
      end else begin
         pass2.nxt   = pass1.nxt;
         pass2.emit  = 1'b0;
         pass2.again = 1'b0;
      end
      flush      = req_stream_end && (pass2.nxt == M_SLASH);
      first_byte = (mode_ff == M_SLASH) ? CH_SLASH : req_in_byte;
   end

   always_comb begin
      q_entry.two = (pass1.emit && pass2.emit) || (pass1.emit && flush) ||
                    (pass2.emit && flush);
      q_entry.b0  = pass1.emit ? first_byte : (pass2.emit ? req_in_byte : CH_SLASH);
      q_entry.b1  = (pass1.emit && pass2.emit) ? req_in_byte : CH_SLASH;
      q_push      = accept && (pass1.emit || pass2.emit || flush);
      mode_in     = mode_ff;
      if (accept) mode_in = req_stream_end ? M_NORMAL : pass2.nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= M_NORMAL;
      else mode_ff <= mode_in;
   end

   assign front_stat.mode = mode_ff;

endmodule

`default_nettype wire

### rtl/ccs_fifo.sv
// Short register queue of classified entries between front and back end.
`default_nettype none

module ccs_fifo import ccs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  entry_type       push_entry,
   input  wire logic       pop,
   output entry_type       head_entry,
   output q_status_type    stat
);

   entry_type         slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign do_push = push && (cnt_ff != QCNT_W'(QDEPTH));
   assign do_pop  = pop && (cnt_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_entry;
   end

   assign head_entry  = slot_ff[rd_ptr_ff];
   assign stat.full   = (cnt_ff == QCNT_W'(QDEPTH));
   assign stat.empty  = (cnt_ff == '0);
   assign stat.count  = cnt_ff;

endmodule

`default_nettype wire

### rtl/ccs_back.sv
// Back end: output register that hands out queue entries one byte per beat.
`default_nettype none

module ccs_back import ccs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  entry_type        head_entry,
   input  wire logic        q_empty,
   output logic             q_pop,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_run_last
);

   entry_type ent_ff, ent_in;
   logic      valid_ff, valid_in;
   logic      phase_ff, phase_in;
   logic      taken, finishing, advance, load;

   assign taken     = valid_ff && rsp_pop;
   assign finishing = taken && (!ent_ff.two || phase_ff);
   assign advance   = taken && ent_ff.two && !phase_ff;
   assign load      = (!valid_ff || finishing) && !q_empty;

   always_comb begin
      ent_in   = load ? head_entry : ent_ff;
      valid_in = load ? 1'b1 : (finishing ? 1'b0 : valid_ff);
      phase_in = load ? 1'b0 : (advance ? 1'b1 : phase_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign q_pop        = load;
   assign rsp_empty    = !valid_ff;
   assign rsp_out_byte = phase_ff ? ent_ff.b1 : ent_ff.b0;
   assign rsp_run_last = !ent_ff.two || phase_ff;

endmodule

`default_nettype wire
